// ===== hw/rtl/positional_list_insert_delete_macros.svh =====
// ----------------------------------------------------------------------------
// Positional list assertion macros
// Shared concurrent assertion helpers, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

// checked only while out of reset
`define PLI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PLI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional list package
// Beat types, operation and status codes shared by the list cells and top.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int VAL_W = 32;
    localparam int POS_W = 8;
    localparam int ST_W  = 2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic                     mode;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
    } t_in;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [VAL_W-1:0]  removed_value;
    } t_out;

    // per-beat command broadcast to every cell
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [POS_W-1:0]         slot;
        logic signed [VAL_W-1:0]  value;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/positional_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// Positional list insert / delete
// Ordered list of signed words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A new item is taken every cycle while results are
// not held back; all cells shift together at the accept edge. The removed
// value is gathered by a two-level OR tree (groups of sixteen cells, then the
// groups), registered once per level: the group ORs in the middle stage, the
// full OR in the output register. An output register and the middle tree stage
// let intake continue while a result waits. The list starts empty; unused
// slots hold no defined value and need no clearing.
module positional_list_insert_delete
    import pli_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    `include "positional_list_insert_delete_macros.svh"

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GRP    = 16;
    localparam int NGROUP = (CAPACITY + GRP - 1) / GRP;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic                    r_p1_valid;
    logic [ST_W-1:0]         r_p1_status;
    logic                    r_p1_take;
    logic signed [VAL_W-1:0] r_grp [NGROUP];

    logic r_out_valid;
    t_out r_out;

    logic in_acc;
    logic p1_move;
    logic pos_zero;
    logic [POS_W-1:0] slot;
    logic [CMP_W-1:0] slot_c;
    logic [CMP_W-1:0] count_c;
    logic ins_ok;
    logic del_ok;
    logic [ST_W-1:0] status;
    t_cell_ctl ctl;
    logic signed [VAL_W-1:0] grp_or [NGROUP];
    logic signed [VAL_W-1:0] removed;

    logic signed [VAL_W-1:0] w_value [CAPACITY];
    logic signed [VAL_W-1:0] w_tap   [CAPACITY];

    assign p1_move = r_p1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_p1_valid || p1_move;
    assign in_acc  = i_valid && o_ready;

    assign pos_zero = (i_data.position == '0);
    assign slot     = i_data.position - POS_W'(1);
    assign slot_c   = CMP_W'(slot);
    assign count_c  = CMP_W'(r_count);

    always_comb begin
        ins_ok = 1'b0;
        del_ok = 1'b0;
        status = ST_BADPOS;
        if (!pos_zero) begin
            if (i_data.mode == MODE_INSERT) begin
                if (slot_c <= count_c) begin
                    if (count_c < CAP_C) begin
                        ins_ok = 1'b1;
                        status = ST_DONE;
                    end else begin
                        status = ST_FULL;
                    end
                end
            end else begin
                if (slot_c < count_c) begin
                    del_ok = 1'b1;
                    status = ST_DONE;
                end
            end
        end
    end

    always_comb begin
        ctl.ins   = in_acc && ins_ok;
        ctl.del   = in_acc && del_ok;
        ctl.slot  = slot;
        ctl.value = i_data.value;
    end

    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [VAL_W-1:0] left_v;
            logic signed [VAL_W-1:0] right_v;
            if (gi == 0) begin : g_first
                assign left_v = w_value[gi];
            end else begin : g_mid_l
                assign left_v = w_value[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_v = w_value[gi];
            end else begin : g_mid_r
                assign right_v = w_value[gi+1];
            end
            pli_cell #(
                .IDX (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_left  (left_v),
                .i_right (right_v),
                .o_value (w_value[gi]),
                .o_tap   (w_tap[gi])
            );
        end
    endgenerate

    // first tree level: OR of the taps in each group of sixteen cells
    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            grp_or[g] = '0;
            for (int j = 0; j < GRP; j++) begin
                if (g * GRP + j < CAPACITY) begin
                    grp_or[g] = grp_or[g] | w_tap[g * GRP + j];
                end
            end
        end
    end

    always_comb begin
        removed = '0;
        for (int g = 0; g < NGROUP; g++) begin
            removed = removed | r_grp[g];
        end
        if (!r_p1_take) begin
            removed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_acc) begin
                r_p1_valid <= 1'b1;
            end else if (p1_move) begin
                r_p1_valid <= 1'b0;
            end
            if (p1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p1_status <= status;
            r_p1_take   <= del_ok;
            for (int g = 0; g < NGROUP; g++) begin
                r_grp[g] <= grp_or[g];
            end
        end
        if (p1_move) begin
            r_out.status        <= r_p1_status;
            r_out.removed_value <= removed;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `PLI_ASSERT(a_count_cap, (CMP_W'(r_count) <= CAP_C), "list count above capacity")
    `PLI_ASSERT(a_ins_count, (ctl.ins |=> (r_count == $past(r_count) + CNT_W'(1))), "insert did not grow count")
    `PLI_ASSERT(a_del_count, (ctl.del |=> (r_count == $past(r_count) - CNT_W'(1))), "delete did not shrink count")
    `PLI_ASSERT(a_fail_zero, ((o_valid && (o_data.status != ST_DONE)) |-> (o_data.removed_value == '0)), "rejected beat carries a value")
    `PLI_ASSERT_ALWAYS(a_rst_empty, ((!i_rst_n) |=> ((r_count == '0) && !r_p1_valid && !o_valid)), "reset left state behind")

endmodule

// ===== hw/rtl/pli_cell.sv =====
// ----------------------------------------------------------------------------
// Positional list cell
// One list slot; on insert, new value at the slot, left neighbor past it;
// on delete, right neighbor from the slot on; taps its value when addressed.
// ----------------------------------------------------------------------------
module pli_cell
    import pli_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic signed [VAL_W-1:0] i_left,
    input  logic signed [VAL_W-1:0] i_right,
    output logic signed [VAL_W-1:0] o_value,
    output logic signed [VAL_W-1:0] o_tap
);

    localparam logic [POS_W-1:0] IDX_L = POS_W'(IDX);

    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (IDX_L > i_ctl.slot) begin
                n_value = i_left;
            end else if (IDX_L == i_ctl.slot) begin
                n_value = i_ctl.value;
            end
        end else if (i_ctl.del) begin
            if (IDX_L >= i_ctl.slot) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_tap   = (IDX_L == i_ctl.slot) ? r_value : '0;

endmodule

// ===== tb/tb_positional_list_insert_delete.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional list insert / delete testbench
// A directed table first: edge cases, fill to capacity, deletes at both ends.
// Then random insert/delete traffic across four idle/stall phases. Each
// result is checked in order against a local model of the list or a pinned status.
// ----------------------------------------------------------------------------
module tb_positional_list_insert_delete;
    import pli_pkg::*;

    localparam int CAP        = 16;
    localparam int DIR_N      = 25;
    localparam int RAND_PER_PH = 262;

    typedef struct packed {
        logic                    mode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
        logic                    pinned;
        logic [ST_W-1:0]         pin_status;
    } t_dir_row;

    // expected status typed in where it is known on sight; removed value is zero there
    typedef struct {
        bit   on;
        t_out res;
    } t_pin;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_data  = '0;
    logic o_ready;
    logic o_valid;
    t_out o_data;

    // local copy of the list, advanced on each accepted input beat
    logic signed [VAL_W-1:0] list_vals [CAP];
    int                      list_count = 0;
    // count as seen by the stimulus side, used to aim positions
    int                      issue_count = 0;

    t_out result_q [$];
    t_pin pinned_q [$];
    int   mismatches   = 0;
    int   src_idle_pct = 0;
    int   snk_stall_pct = 0;
    bit   fill_mode    = 1'b1;

    t_dir_row dir_rows [DIR_N] = '{
        '{MODE_DELETE, 8'd1,   32'sh0000_0000, 1'b1, ST_BADPOS},  // delete from empty
        '{MODE_INSERT, 8'd0,   32'sh1111_1111, 1'b1, ST_BADPOS},  // position zero
        '{MODE_DELETE, 8'd0,   32'sh0000_0000, 1'b1, ST_BADPOS},
        '{MODE_INSERT, 8'd2,   32'sh2222_2222, 1'b1, ST_BADPOS},  // past end
        '{MODE_INSERT, 8'd1,   32'sh7FFF_FFFF, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd1,   32'sh8000_0000, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd3,   32'shFFFF_FFFF, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd2,   32'sh0000_0000, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd5,   32'sh5555_5555, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd3,   32'shAAAA_AAAA, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd1,   32'sh0000_0001, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd8,   32'sh1234_5678, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd4,   32'shFEDC_BA98, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd10,  32'sh0F0F_0F0F, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd6,   32'shF0F0_F0F0, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd12,  32'sh3333_3333, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd7,   32'shCCCC_CCCC, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd14,  32'sh00FF_00FF, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd2,   32'shFF00_FF00, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd16,  32'sh1357_9BDF, 1'b0, ST_DONE},
        '{MODE_INSERT, 8'd17,  32'sh7777_7777, 1'b1, ST_FULL},    // full, valid position
        '{MODE_INSERT, 8'd255, 32'sh8888_8888, 1'b1, ST_BADPOS},  // bad position wins over full
        '{MODE_DELETE, 8'd16,  32'sh0000_0000, 1'b0, ST_DONE},
        '{MODE_DELETE, 8'd1,   32'shFFFF_FFFF, 1'b0, ST_DONE},
        '{MODE_DELETE, 8'd8,   32'sh0000_0000, 1'b0, ST_DONE}
    };

    positional_list_insert_delete #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    function automatic t_out apply_list_op(t_in op);
        t_out res;
        int   slot;
        int   k;
        res.status        = ST_DONE;
        res.removed_value = '0;
        if (op.position == 0) begin
            res.status = ST_BADPOS;
        end else begin
            slot = int'(op.position) - 1;
            if (op.mode == MODE_INSERT) begin
                if (slot > list_count) begin
                    res.status = ST_BADPOS;
                end else if (list_count >= CAP) begin
                    res.status = ST_FULL;
                end else begin
                    for (k = list_count; k > slot; k--) list_vals[k] = list_vals[k-1];
                    list_vals[slot] = op.value;
                    list_count++;
                end
            end else begin
                if (slot >= list_count) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.removed_value = list_vals[slot];
                    for (k = slot; k + 1 < list_count; k++) list_vals[k] = list_vals[k+1];
                    list_count--;
                end
            end
        end
        return res;
    endfunction

    // result side is checked before intake so a stray beat never matches a fresh item
    always @(posedge i_clk) begin
        t_out exp_res;
        t_out pred;
        t_pin pin;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (result_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, got status %0d removed %0d",
                             $time, o_data.status, o_data.removed_value);
                end else begin
                    exp_res = result_q.pop_front();
                    if (o_data.status !== exp_res.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, exp_res.status, o_data.status);
                    end
                    if (o_data.removed_value !== exp_res.removed_value) begin
                        mismatches++;
                        $display("%0t: removed_value expected %0d, got %0d",
                                 $time, exp_res.removed_value, o_data.removed_value);
                    end
                end
            end
            if (i_valid && o_ready) begin
                pred = apply_list_op(i_data);
                pin  = pinned_q.pop_front();
                result_q.push_back(pin.on ? pin.res : pred);
            end
        end
    end

    task automatic send_op(input t_in op, input bit pinned, input logic [ST_W-1:0] pin_st);
        t_pin pin;
        int   slot;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        pin.on                = pinned;
        pin.res.status        = pin_st;
        pin.res.removed_value = '0;
        pinned_q.push_back(pin);
        i_valid <= 1'b1;
        i_data  <= op;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        slot = int'(op.position) - 1;
        if (op.position != 0) begin
            if (op.mode == MODE_INSERT && slot <= issue_count && issue_count < CAP)
                issue_count++;
            else if (op.mode == MODE_DELETE && slot < issue_count)
                issue_count--;
        end
    endtask

    // mostly well-formed positions, drifting between filling and draining
    task automatic make_random_op(output t_in op);
        int r;
        int past;
        r = $urandom_range(99);
        if (issue_count >= CAP) fill_mode = 1'b0;
        else if (issue_count == 0) fill_mode = 1'b1;
        else if ($urandom_range(39) == 0) fill_mode = !fill_mode;
        op.value = $urandom;
        if (r < 8) begin
            op.mode     = 1'($urandom_range(1));
            op.position = POS_W'($urandom_range(255));
        end else if (r < 14) begin
            op.mode = 1'($urandom_range(1));
            past    = (op.mode == MODE_INSERT) ? issue_count + 2 : issue_count + 1;
            op.position = $urandom_range(1) ? POS_W'(0) : POS_W'(past);
        end else begin
            if (issue_count == 0)
                op.mode = MODE_INSERT;
            else
                op.mode = ($urandom_range(99) < (fill_mode ? 70 : 30)) ? MODE_INSERT
                                                                       : MODE_DELETE;
            if (op.mode == MODE_INSERT)
                op.position = POS_W'($urandom_range(issue_count + 1, 1));
            else
                op.position = POS_W'($urandom_range(issue_count, 1));
        end
    endtask

    initial begin
        int   src_pct [4] = '{0, 47, 0, 29};
        int   snk_pct [4] = '{0, 0, 47, 29};
        t_in  op;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct  = src_pct[ph];
            snk_stall_pct = snk_pct[ph];
            if (ph == 0) begin
                for (int n = 0; n < DIR_N; n++) begin
                    op.mode     = dir_rows[n].mode;
                    op.position = dir_rows[n].position;
                    op.value    = dir_rows[n].value;
                    send_op(op, dir_rows[n].pinned, dir_rows[n].pin_status);
                end
            end
            for (int n = 0; n < RAND_PER_PH; n++) begin
                make_random_op(op);
                send_op(op, 1'b0, ST_DONE);
            end
        end
        i_valid       <= 1'b0;
        snk_stall_pct = 0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pli_pkg.sv
hw/rtl/pli_cell.sv
hw/rtl/positional_list_insert_delete.sv
tb/tb_positional_list_insert_delete.sv
